// ----- rtl/gcd_by_common_divisors_assert.svh -----
// Assertion macros for the GCD block.
`ifndef GCD_BY_COMMON_DIVISORS_ASSERT_SVH
`define GCD_BY_COMMON_DIVISORS_ASSERT_SVH
// Assert that a condition implies another on the same edge.
`define GCD_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
	else $error("gcd assertion failed");
// Assert that a condition implies another on the next edge.
`define GCD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
	else $error("gcd assertion failed");
`endif

// ----- rtl/gcd_pkg.sv -----
// Shared types for the GCD block.
package gcd_pkg;
	// Control handed along the cell row.
	typedef struct packed {
		logic valid;
		logic done;
		logic invalid;
	} gcd_ctl_t;
endpackage

// ----- rtl/gcd_if.sv -----
// Valid/ready channel carrying the GCD payloads.
interface gcd_in_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] operand_a;
	logic [W-1:0] operand_b;
	modport source (output valid, operand_a, operand_b, input ready);
	modport sink (input valid, operand_a, operand_b, output ready);
endinterface

interface gcd_out_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] divisor;
	logic         invalid;
	modport source (output valid, divisor, invalid, input ready);
	modport sink (input valid, divisor, invalid, output ready);
endinterface

// ----- rtl/gcd_by_common_divisors.sv -----
// GCD block: a row of 2*DATA_WIDTH binary-GCD cells, one item in flight
// at a time; each result passes through every cell of the row, whose
// length covers the worst-case step chain, into the output register. The
// next input is taken the cycle after the result transfers. Zero operands
// give 0 with invalid set.
module gcd_by_common_divisors #(
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	gcd_in_if.sink   in_ch,
	gcd_out_if.source out_ch
);
	import gcd_pkg::*;
	`include "gcd_by_common_divisors_assert.svh"
	localparam int N  = 2 * DATA_WIDTH;
	localparam int KW = $clog2(DATA_WIDTH + 1);

	gcd_ctl_t              ctl [N+1];
	logic [DATA_WIDTH-1:0] av  [N+1];
	logic [DATA_WIDTH-1:0] bv  [N+1];
	logic [KW-1:0]         kv  [N+1];
	logic                  busy_q, out_valid_q, out_inv_q, zero;
	logic [DATA_WIDTH-1:0] out_div_q;
	logic                  in_xfer;

	assign in_ch.ready = !busy_q;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign zero        = (in_ch.operand_a == '0) || (in_ch.operand_b == '0);

	// Load the head of the row; zero operands skip straight to done.
	assign ctl[0] = '{valid: in_xfer, done: zero, invalid: zero};
	assign av[0]  = in_ch.operand_a;
	assign bv[0]  = in_ch.operand_b;
	assign kv[0]  = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		gcd_cell #(.W(DATA_WIDTH)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(ctl[i]), .a_in(av[i]), .b_in(bv[i]), .k_in(kv[i]),
			.ctl_q(ctl[i+1]), .a_q(av[i+1]), .b_q(bv[i+1]), .k_q(kv[i+1])
		);
	end

	// Hold busy from input transfer until the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				busy_q <= 1'b0;
			end
			if (ctl[N].valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result from the row tail.
	always_ff @(posedge clk) begin
		if (ctl[N].valid) begin
			out_inv_q <= ctl[N].invalid;
			out_div_q <= ctl[N].invalid ? '0 : (av[N] << kv[N]);
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.divisor = out_div_q;
	assign out_ch.invalid = out_inv_q;

	`GCD_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, busy_q, !in_ch.ready)
	`GCD_ASSERT_IMPL(a_tail_done, clk, arst_n, ctl[N].valid, ctl[N].done)
	`GCD_ASSERT_NEXT(a_load_busy, clk, arst_n, in_xfer, busy_q)
	`GCD_ASSERT_IMPL(a_inv_zero, clk, arst_n, out_valid_q && out_inv_q, out_div_q == '0)
endmodule

// ----- rtl/gcd_cell.sv -----
// One binary-GCD step cell: registers a pair and hands it on each cycle.
module gcd_cell #(
	parameter int W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gcd_pkg::gcd_ctl_t ctl_in,
	input  logic [W-1:0]      a_in,
	input  logic [W-1:0]      b_in,
	input  logic [$clog2(W+1)-1:0] k_in,
	output gcd_pkg::gcd_ctl_t ctl_q,
	output logic [W-1:0]      a_q,
	output logic [W-1:0]      b_q,
	output logic [$clog2(W+1)-1:0] k_q
);
	import gcd_pkg::*;
	localparam int KW = $clog2(W+1);
	logic [W-1:0]  a_n, b_n, diff;
	logic [KW-1:0] k_n;
	logic          fin;

	// Apply one Stein step: strip one common two, halve an even operand, or subtract the smaller and halve.
	always_comb begin
		a_n  = a_in;
		b_n  = b_in;
		k_n  = k_in;
		diff = '0;
		fin  = ctl_in.done;
		if (!ctl_in.done) begin
			if (a_in == b_in) begin
				fin = 1'b1;
			end else if (!a_in[0] && !b_in[0]) begin
				a_n = a_in >> 1;
				b_n = b_in >> 1;
				k_n = k_in + KW'(1);
			end else if (!a_in[0]) begin
				a_n = a_in >> 1;
			end else if (!b_in[0]) begin
				b_n = b_in >> 1;
			end else if (a_in > b_in) begin
				diff = a_in - b_in;
				a_n  = diff >> 1;
			end else begin
				diff = b_in - a_in;
				b_n  = diff >> 1;
			end
		end
	end

	// Advance the pair one cell down the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= '{valid: ctl_in.valid, done: fin, invalid: ctl_in.invalid};
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_n;
		b_q <= b_n;
		k_q <= k_n;
	end
endmodule

// ----- verif/gcd_by_common_divisors_checker.sv -----
// Checker for the GCD block: watches both channels, predicts and compares results.
module gcd_by_common_divisors_checker #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] operand_a,
	input  logic [DATA_WIDTH-1:0] operand_b,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [DATA_WIDTH-1:0] divisor,
	input  logic                  invalid,
	output int                    fail_count,
	output int                    pending_count,
	output int                    result_count,
	output int                    invalid_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] divisor;
		logic                  invalid;
	} gcd_result_t;

	gcd_result_t expected_results[$];

	// Euclid on the block's width; zero operand flags invalid
	function automatic gcd_result_t gcd_predict(logic [DATA_WIDTH-1:0] a,
		logic [DATA_WIDTH-1:0] b);
		gcd_result_t r;
		logic [DATA_WIDTH-1:0] x, y, t;
		x = a;
		y = b;
		if (a == '0 || b == '0) begin
			r.divisor = '0;
			r.invalid = 1'b1;
		end else begin
			while (y != '0) begin
				t = x % y;
				x = y;
				y = t;
			end
			r.divisor = x;
			r.invalid = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
		invalid_count = 0;
	end

	assign pending_count = expected_results.size();

	// Queue predictions on input transfer, compare on output transfer
	always @(posedge clk) begin
		gcd_result_t exp_r;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(gcd_predict(operand_a, operand_b));
			if (out_valid && out_ready) begin
				result_count++;
				if (invalid)
					invalid_count++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result divisor=%0d invalid=%0b",
						divisor, invalid));
				end else begin
					exp_r = expected_results.pop_front();
					if (divisor !== exp_r.divisor)
						report_mismatch($sformatf("divisor got %0d want %0d",
							divisor, exp_r.divisor));
					if (invalid !== exp_r.invalid)
						report_mismatch($sformatf("invalid got %0b want %0b",
							invalid, exp_r.invalid));
				end
			end
		end
	end
endmodule

// ----- verif/tb_gcd_by_common_divisors.sv -----
// Testbench top for the GCD block: stimulus, stalls, watchdog and verdict.
module tb_gcd_by_common_divisors;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_WIDTH = 32;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2 * DATA_WIDTH + 20;
	localparam int STALL_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   fail_count, pending_count, result_count, invalid_count;
	int   idle_cycles;
	bit   hold_off;

	gcd_in_if  #(.W(DATA_WIDTH)) in_ch();
	gcd_out_if #(.W(DATA_WIDTH)) out_ch();

	gcd_by_common_divisors #(.DATA_WIDTH(DATA_WIDTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	gcd_by_common_divisors_checker #(.DATA_WIDTH(DATA_WIDTH)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.operand_a(in_ch.operand_a),
		.operand_b(in_ch.operand_b),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.divisor(out_ch.divisor),
		.invalid(out_ch.invalid),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.result_count(result_count),
		.invalid_count(invalid_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 150);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_word();
		logic [DATA_WIDTH-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 3))
			0: w = w >> $urandom_range(0, DATA_WIDTH - 1);
			1: w = ~w >> $urandom_range(0, 4);
			default: ;
		endcase
		return w;
	endfunction

	// Offer one pair and hold it until transfer; drop valid only across a gap
	task automatic send_pair(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
		int gap;
		gap = gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// Build pairs: half share a random common factor, the rest are equal/zero or random words
	task automatic send_random();
		logic [DATA_WIDTH-1:0] f, a, b;
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) begin
			f = $urandom_range(1, 1 << $urandom_range(0, 16));
			a = f * $urandom_range(0, 65535);
			b = f * $urandom_range(0, 65535);
			send_pair(a, b);
		end else if (k == 5) begin
			a = rand_word();
			send_pair(a, ($urandom_range(0, 1) ? a : '0));
		end else begin
			send_pair(rand_word(), rand_word());
		end
	endtask

	// Receiver: random stalls, plus one long hold-off
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
			end else begin
				gap = gap_len();
				if (gap == 0) begin
					out_ch.ready <= 1'b1;
				end else begin
					out_ch.ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("gcd_by_common_divisors verification failed");
				$finish;
			end
		end
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		hold_off = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zeros, extremes, equal operands, coprime and power-of-two pairs
		send_pair('0, '0);
		send_pair('0, 32'd5);
		send_pair(32'd7, '0);
		send_pair('1, '0);
		send_pair('1, '1);
		send_pair(32'd1, 32'd1);
		send_pair(32'd1, '1);
		send_pair('1, 32'd1);
		send_pair(32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h4000_0000);
		send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_pair(32'd12, 32'd18);
		send_pair(32'd18, 32'd12);
		send_pair(32'd1836311903, 32'd2971215073);
		send_pair(32'hAAAA_AAAA, 32'h5555_5555);
		send_pair(32'd4294967291, 32'd4294967279);
		send_pair(32'd123456, 32'd123456);
		send_pair(32'd3, 32'd3);
		send_pair(32'hFFFF_0000, 32'h0000_FFFF);

		// Hold off the receiver while the sender keeps offering
		hold_off = 1'b1;
		fork
			begin
				repeat (STALL_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (8) send_random();
		join

		repeat (RANDOM_ITEMS) send_random();
		@(negedge clk);
		in_ch.valid <= 1'b0;

		waited = 0;
		while (pending_count != 0) @(posedge clk);
		while (waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end

		$display("covered %0d results, %0d flagged invalid, incl. zero, extreme,",
			result_count, invalid_count);
		$display("equal and shared-factor operands with stalls on both sides");
		if (fail_count == 0)
			$display("gcd_by_common_divisors verification clean");
		else
			$display("gcd_by_common_divisors verification failed");
		$finish;
	end
endmodule
